@@ hw/rtl/gn3_pkg.sv @@
`default_nettype none
package gn3_pkg;

  localparam int FracBitsDefault = 16;

  typedef logic [7:0] perm_t;

  localparam perm_t PermRom [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,8'd194,
    8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,8'd37,8'd240,
    8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,8'd0,8'd26,8'd197,
    8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,
    8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,
    8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,
    8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
    8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,8'd1,
    8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,8'd18,8'd169,8'd200,
    8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,8'd100,8'd109,8'd198,8'd173,
    8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,
    8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,
    8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,
    8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
    8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
    8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,
    8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,
    8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,
    8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,
    8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,
    8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
  };

endpackage
`default_nettype wire

@@ hw/rtl/gn3_mulq.sv @@
`default_nettype none
// signed q-format product, rounded half up, one register stage
module gn3_mulq #(
  parameter int AW = 20,
  parameter int BW = 20,
  parameter int OW = 20,
  parameter int FB = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic signed [OW-1:0]      p
);
  localparam int PW = AW + BW;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;

  always_comb begin
    prod = PW'(a) * PW'(b);
    rnd  = (prod + (PW'(1) <<< (FB - 1))) >>> FB;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= OW'(rnd);
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/gradient_noise_3d.sv @@
`default_nettype none
// 3d improved gradient noise, one point per clock while the output is not stalled. each
// transfer carries three signed fixed-point coordinates with FRAC_BITS fraction bits; the
// result is (n+1)/2 as an unsigned 16-bit fraction, saturated. the fade multipliers and
// permutation rom lookups are fully pipelined, so a new point is taken while earlier ones
// are still in flight. a stall on the output freezes the whole pipe in place.
module gradient_noise_3d #(
  parameter int FRAC_BITS = gn3_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_coord,
  input  wire logic [31:0] z_coord,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      noise_value
);
  import gn3_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int DW = F + 5;       // grads/lerps stay within about +-3
  localparam int FW = F + 6;       // fade intermediates reach about -15
  localparam int RW = DW + 16;     // room for the left shift at small FRAC_BITS
  localparam int NS = 10;

  logic [NS-1:0] vld;
  logic          adv;

  // single enable pipeline: advance unless the head is stalled
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  // stage 1: split coordinates
  logic [7:0]   c1x, c1y, c1z;
  logic [F-1:0] f1 [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      c1x   <= x_coord[F +: 8];
      c1y   <= y_coord[F +: 8];
      c1z   <= z_coord[F +: 8];
      f1[0] <= x_coord[F-1:0];
      f1[1] <= y_coord[F-1:0];
      f1[2] <= z_coord[F-1:0];
    end
  end

  // fade per axis: 4 chained rounded products (stages 2..5), fraction delayed alongside
  logic signed [FW-1:0] fm1 [3];
  logic signed [FW-1:0] fm2 [3];
  logic signed [FW-1:0] fm3 [3];
  logic signed [FW-1:0] fm4 [3];
  logic [F-1:0] fd [3][4];
  logic signed [FW-1:0] fa0 [3];
  logic signed [FW-1:0] fa1 [3];

  for (genvar k = 0; k < 3; k++) begin : g_fade
    always_comb begin
      fa0[k] = FW'(6) * $signed({1'b0, f1[k]}) - (FW'(15) <<< F);
      fa1[k] = fm1[k] + (FW'(10) <<< F);
    end
    gn3_mulq #(.AW(F+1), .BW(FW), .OW(FW), .FB(F)) u_m1 (
      .clk(clk), .en(adv), .a($signed({1'b0, f1[k]})), .b(fa0[k]), .p(fm1[k]));
    gn3_mulq #(.AW(F+1), .BW(FW), .OW(FW), .FB(F)) u_m2 (
      .clk(clk), .en(adv), .a($signed({1'b0, fd[k][0]})), .b(fa1[k]), .p(fm2[k]));
    gn3_mulq #(.AW(F+1), .BW(FW), .OW(FW), .FB(F)) u_m3 (
      .clk(clk), .en(adv), .a($signed({1'b0, fd[k][1]})), .b(fm2[k]), .p(fm3[k]));
    gn3_mulq #(.AW(F+1), .BW(FW), .OW(FW), .FB(F)) u_m4 (
      .clk(clk), .en(adv), .a($signed({1'b0, fd[k][2]})), .b(fm3[k]), .p(fm4[k]));
    always_ff @(posedge clk) begin
      if (adv) begin
        fd[k][0] <= f1[k];
        for (int i = 1; i < 4; i++) fd[k][i] <= fd[k][i-1];
      end
    end
  end

  // hash chain over stages 2..5, aligned with fade
  logic [7:0] pa2, pb2, cy2, cz2, cz3;
  logic [7:0] a3, b3;
  logic [7:0] haa, hab, hba, hbb;
  logic [7:0] h4 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      pa2 <= PermRom[c1x];
      pb2 <= PermRom[8'(c1x + 8'd1)];
      cy2 <= c1y;
      cz2 <= c1z;
      a3  <= 8'(pa2 + cy2);
      b3  <= 8'(pb2 + cy2);
      cz3 <= cz2;
      haa <= 8'(PermRom[a3] + cz3);
      hab <= 8'(PermRom[8'(a3 + 8'd1)] + cz3);
      hba <= 8'(PermRom[b3] + cz3);
      hbb <= 8'(PermRom[8'(b3 + 8'd1)] + cz3);
    end
  end
  // corner order: bit0 = x, bit1 = y, bit2 = z
  logic [7:0] h5 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      h5[0] <= PermRom[haa];
      h5[1] <= PermRom[hba];
      h5[2] <= PermRom[hab];
      h5[3] <= PermRom[hbb];
      h5[4] <= PermRom[8'(haa + 8'd1)];
      h5[5] <= PermRom[8'(hba + 8'd1)];
      h5[6] <= PermRom[8'(hab + 8'd1)];
      h5[7] <= PermRom[8'(hbb + 8'd1)];
    end
  end
  assign h4 = h5;

  // stage 6: fades clamped, gradients computed
  logic [F:0] fu [3];
  logic signed [DW-1:0] g6 [8];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        if (fm4[k] < 0)                        fu[k] <= '0;
        else if (fm4[k] > (FW'(1) <<< F))      fu[k] <= {1'b1, {F{1'b0}}};
        else                                   fu[k] <= (F+1)'(fm4[k]);
      end
      for (int c = 0; c < 8; c++) begin
        logic signed [DW-1:0] px, py, pz, gu, gv;
        logic [3:0] h;
        px = c[0] ? $signed(DW'({1'b0, fd[0][3]})) - (DW'(1) <<< F)
                  : $signed(DW'({1'b0, fd[0][3]}));
        py = c[1] ? $signed(DW'({1'b0, fd[1][3]})) - (DW'(1) <<< F)
                  : $signed(DW'({1'b0, fd[1][3]}));
        pz = c[2] ? $signed(DW'({1'b0, fd[2][3]})) - (DW'(1) <<< F)
                  : $signed(DW'({1'b0, fd[2][3]}));
        h  = h4[c][3:0];
        gu = (h < 4'd8) ? px : py;
        gv = (h < 4'd4) ? py : ((h == 4'd12 || h == 4'd14) ? px : pz);
        g6[c] <= (h[0] ? -gu : gu) + (h[1] ? -gv : gv);
      end
    end
  end

  // stages 7..9: lerp levels x, y, z (product registered inside gn3_mulq)
  logic signed [DW-1:0] d7 [4];
  logic signed [DW-1:0] m7 [4];
  logic signed [DW-1:0] a7 [4];
  logic signed [DW-1:0] l8 [4];
  logic [F:0] fv7, fw7, fw8;
  logic signed [DW-1:0] m8 [2];
  logic signed [DW-1:0] a8 [2];
  logic signed [DW-1:0] d8 [2];
  logic signed [DW-1:0] m9, a9, d9;

  for (genvar j = 0; j < 4; j++) begin : g_lx
    assign d7[j] = g6[2*j+1] - g6[2*j];
    gn3_mulq #(.AW(F+2), .BW(DW), .OW(DW), .FB(F)) u_lx (
      .clk(clk), .en(adv), .a($signed({1'b0, fu[0]})), .b(d7[j]), .p(m7[j]));
    always_ff @(posedge clk) if (adv) a7[j] <= g6[2*j];
    assign l8[j] = a7[j] + m7[j];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      fv7 <= fu[1];
      fw7 <= fu[2];
      fw8 <= fw7;
    end
  end
  for (genvar j = 0; j < 2; j++) begin : g_ly
    assign d8[j] = l8[2*j+1] - l8[2*j];
    gn3_mulq #(.AW(F+2), .BW(DW), .OW(DW), .FB(F)) u_ly (
      .clk(clk), .en(adv), .a($signed({1'b0, fv7})), .b(d8[j]), .p(m8[j]));
    always_ff @(posedge clk) if (adv) a8[j] <= l8[2*j];
  end
  assign d9 = (a8[1] + m8[1]) - (a8[0] + m8[0]);
  gn3_mulq #(.AW(F+2), .BW(DW), .OW(DW), .FB(F)) u_lz (
    .clk(clk), .en(adv), .a($signed({1'b0, fw8})), .b(d9), .p(m9));
  always_ff @(posedge clk) if (adv) a9 <= a8[0] + m8[0];

  // stage 10: remap (n+1)/2 and saturate
  logic signed [DW:0] s9;
  logic [RW-1:0]      r9;
  always_comb begin
    s9 = DW'(a9 + m9) + ((DW+1)'(1) <<< F);
    if (s9 < 0) s9 = '0;
    if (F > 15) r9 = (RW'($unsigned(s9)) + (RW'(1) << ((F > 15 ? F - 15 : 1) - 1)))
                     >> (F > 15 ? F - 15 : 0);
    else        r9 = RW'($unsigned(s9)) << (F < 15 ? 15 - F : 0);
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      noise_value <= (r9 > RW'(65535)) ? 16'hffff : r9[15:0];
    end
  end

  // nothing moves while the head is held
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value))
    else $error("result changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    adv && vld[NS-2] |=> out_valid)
    else $error("item lost at output stage");
endmodule
`default_nettype wire

@@ tb/gradient_noise_3d_tb.sv @@
`default_nettype none
module gradient_noise_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = gn3_pkg::FracBitsDefault;
  localparam longint ONE = longint'(1) << FB;
  localparam int LATENCY = 10;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] x_coord = '0;
  logic [31:0] y_coord = '0;
  logic [31:0] z_coord = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] noise_value;

  gradient_noise_3d dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .out_valid(out_valid), .out_stall(out_stall),
    .noise_value(noise_value)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  point_t pending_points[$];
  logic [15:0] expected_noise[$];
  int errors = 0;
  int cycle = 0;
  // idle rates in percent for each side, changed by the stimulus phases
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_send = 1'b0;

  // fixed-point helpers for the noise predictor
  function automatic longint round_frac(longint p);
    longint q;
    q = p + (longint'(1) << (FB - 1));
    return q >>> FB;
  endfunction

  function automatic longint fade(longint t);
    longint r;
    r = 6 * t - 15 * ONE;
    r = round_frac(t * r) + 10 * ONE;
    r = round_frac(t * r);
    r = round_frac(t * r);
    r = round_frac(t * r);
    if (r < 0) r = 0;
    if (r > ONE) r = ONE;
    return r;
  endfunction

  function automatic longint blend(longint t, longint a, longint b);
    return a + round_frac(t * (b - a));
  endfunction

  function automatic longint corner_dot(logic [7:0] hash, longint x, longint y, longint z);
    logic [3:0] h;
    longint u, v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  function automatic logic [7:0] hash_of(logic [7:0] i);
    return gn3_pkg::PermRom[i];
  endfunction

  function automatic logic [15:0] predict_noise(point_t p);
    logic [7:0] cx, cy, cz, a, b, aa, ab, ba, bb;
    longint fx, fy, fz, gx, gy, gz, u, v, w, x00, x10, x01, x11, n, s;
    cx = p.x[FB +: 8];
    cy = p.y[FB +: 8];
    cz = p.z[FB +: 8];
    fx = longint'(p.x[FB-1:0]);
    fy = longint'(p.y[FB-1:0]);
    fz = longint'(p.z[FB-1:0]);
    u = fade(fx);
    v = fade(fy);
    w = fade(fz);
    gx = fx - ONE;
    gy = fy - ONE;
    gz = fz - ONE;
    // 8-bit sums wrap, as in the hash chain of the design
    a = hash_of(cx) + cy;
    aa = hash_of(a) + cz;
    ab = hash_of(a + 8'd1) + cz;
    b = hash_of(cx + 8'd1) + cy;
    ba = hash_of(b) + cz;
    bb = hash_of(b + 8'd1) + cz;
    x00 = blend(u, corner_dot(hash_of(aa), fx, fy, fz), corner_dot(hash_of(ba), gx, fy, fz));
    x10 = blend(u, corner_dot(hash_of(ab), fx, gy, fz), corner_dot(hash_of(bb), gx, gy, fz));
    x01 = blend(u, corner_dot(hash_of(aa + 8'd1), fx, fy, gz),
                corner_dot(hash_of(ba + 8'd1), gx, fy, gz));
    x11 = blend(u, corner_dot(hash_of(ab + 8'd1), fx, gy, gz),
                corner_dot(hash_of(bb + 8'd1), gx, gy, gz));
    n = blend(w, blend(v, x00, x10), blend(v, x01, x11));
    s = n + ONE;
    if (s < 0) s = 0;
    if (FB > 15) s = (s + (longint'(1) << (FB > 15 ? FB - 16 : 0))) >>> (FB > 15 ? FB - 15 : 0);
    else s = s <<< (FB < 15 ? 15 - FB : 0);
    if (s > 65535) s = 65535;
    return s[15:0];
  endfunction

  // driver: present the next point, hold it while stalled
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_noise.push_back(predict_noise({x_coord, y_coord, z_coord}));
        if (pending_points.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          point_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          x_coord <= p.x;
          y_coord <= p.y;
          z_coord <= p.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result transfer and randomize the output stall
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_noise.size() == 0) begin
          $error("noise_value: unexpected result %0d", noise_value);
          errors++;
        end else begin
          logic [15:0] want;
          want = expected_noise.pop_front();
          if (noise_value !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, noise_value);
            errors++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle++;
    if (cycle > LIMIT) begin
      $display("** gradient_noise_3d: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      // small lattice neighborhood, both signs
      1: return ($urandom() >> 8) ^ ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0);
      // fraction near cell edges
      2: return {16'($urandom_range(65535)), 16'h0} | 32'($urandom_range(3)) |
                ($urandom_range(1) ? 32'h0000_FFF0 : 32'h0);
      default: return {16'($urandom_range(511) - 256), 16'(($urandom()))};
    endcase
  endfunction

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    pending_points.push_back('{x: x, y: y, z: z});
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_noise.size() > 0)
      @(posedge clk);
  endtask

  task automatic drain_results();
    while (in_valid || expected_noise.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, cell wrap, integer lattice points, all fraction bits
    foreach (edges[i]) queue_point(edges[i], edges[(i + 1) % 6], edges[(i + 2) % 6]);
    queue_point(32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
    queue_point(32'hFFFF_0000, 32'h0100_0000, 32'h0000_0001);
    queue_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    queue_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    // walk the corner hashes across cells
    for (int i = 0; i < 12; i++)
      queue_point({8'h0, 8'(i * 21), 16'h4000}, {8'h0, 8'(i * 7), 16'hC000},
                  {8'hFF, 8'(i * 13), 16'h8000});

    // sender idles 26%, receiver 68%
    send_idle = 26;
    recv_idle = 68;
    repeat (130) queue_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    // swap idle rates; midway the sender pauses until every result is back
    send_idle = 68;
    recv_idle = 26;
    repeat (130) queue_point(rand_coord(), rand_coord(), rand_coord());
    while (pending_points.size() > 65) @(posedge clk);
    hold_send = 1'b1;
    @(posedge clk);
    drain_results();
    hold_send = 1'b0;
    drain();

    // full rate on both sides
    send_idle = 0;
    recv_idle = 0;
    repeat (140) queue_point(rand_coord(), rand_coord(), rand_coord());
    drain();

    repeat (LATENCY * 3) @(posedge clk);
    if (errors == 0 && expected_noise.size() == 0) begin
      $display("** gradient_noise_3d: PASSED **");
    end else begin
      $display("** gradient_noise_3d: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
